### rtl/bsel_pkg.sv
// shared types and constants for the backend selector
package bsel_pkg;

    localparam int NUM_BACKENDS_DEF = 8;
    localparam int WEIGHT_BITS_DEF  = 8;
    localparam int MAX_ACTIVE_DEF   = 4096;

    localparam int IDX_W       = 3;
    localparam int CNT_W       = 4;
    localparam int WGT_W       = 8;
    localparam int ACT_W       = 13;
    localparam int RW_W        = 13;
    localparam int KEY_W       = 32;
    localparam int CMD_W       = 2;
    localparam int MODE_W      = 2;
    localparam int TOT_W       = WGT_W + IDX_W + 1;
    localparam int SUM_W       = RW_W + 2;
    localparam int SCORE_SCALE = 100;
    localparam int SCALE_W     = 7;
    localparam int SCORE_W     = ACT_W + SCALE_W;
    localparam int QBITS_STEP  = 4;
    localparam int DIV_STEPS   = SCORE_W / QBITS_STEP;
    localparam int DCNT_W      = $clog2(DIV_STEPS);
    localparam int MOD_STEPS   = KEY_W / 2;
    localparam int MCNT_W      = $clog2(MOD_STEPS);
    localparam int RW_MAX      = 4095;
    localparam int RW_MIN      = -4096;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    localparam logic [CNT_W-1:0] COUNT_RESET   = CNT_W'(1);
    localparam logic [DATA_W-1:0] WEIGHTS_RESET = 64'h0101010101010101;

    typedef enum logic [CMD_W-1:0] {
        CMD_SELECT = 2'd0,
        CMD_HEALTH = 2'd1,
        CMD_OPEN   = 2'd2,
        CMD_CLOSE  = 2'd3
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_RR   = 2'd0,
        MODE_WRR  = 2'd1,
        MODE_LC   = 2'd2,
        MODE_HASH = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE    = 2'd0,
        REG_COUNT   = 2'd1,
        REG_WEIGHTS = 2'd2,
        REG_NONE    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic load;
        logic mod_init;
        logic mod_src_key;
        logic mod_step;
        logic scan_init;
        logic scan_step;
        logic sel_init;
        logic wrr_step;
        logic lc_skip;
        logic div_init;
        logic div_step;
        logic lc_cmp;
        logic res_best;
        logic wrr_fix;
        logic upd;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic  is_select;
        mode_t mode;
        logic  mod_last;
        logic  k_last;
        logic  i_last;
        logic  up_cur;
        logic  found;
        logic  div_last;
    } dp_stat_t;

endpackage

### rtl/bsel_if.sv
// request and result channel interfaces
interface bsel_in_if;
    logic                        valid;
    logic                        ready;
    logic [bsel_pkg::CMD_W-1:0]  command;
    logic [bsel_pkg::IDX_W-1:0]  target_backend;
    logic                        healthy_bit;
    logic [bsel_pkg::KEY_W-1:0]  client_key;

    modport source (output valid, command, target_backend, healthy_bit, client_key,
                    input ready);
    modport sink (input valid, command, target_backend, healthy_bit, client_key,
                  output ready);
endinterface

interface bsel_out_if;
    logic                        valid;
    logic                        ready;
    logic [bsel_pkg::IDX_W-1:0]  chosen_backend;
    logic                        none_healthy;

    modport source (output valid, chosen_backend, none_healthy, input ready);
    modport sink (input valid, chosen_backend, none_healthy, output ready);
endinterface

### rtl/bsel_cfg.sv
// apb configuration registers
module bsel_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsel_pkg::ADDR_W-1:0]   paddr,
    input  logic [bsel_pkg::DATA_W-1:0]   pwdata,
    output logic [bsel_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output bsel_pkg::mode_t               mode,
    output logic [bsel_pkg::CNT_W-1:0]    backend_count,
    output logic [bsel_pkg::DATA_W-1:0]   weights_packed
);
    import bsel_pkg::*;

    mode_t              mode_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [DATA_W-1:0]  weights_reg;
    reg_idx_t           sel;
    logic               wr;

    assign sel    = reg_idx_t'(paddr[4:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_WRR;
            count_reg   <= COUNT_RESET;
            weights_reg <= WEIGHTS_RESET;
        end
        else if (wr)
        begin
            unique case (sel)
                REG_MODE:    mode_reg    <= mode_t'(pwdata[MODE_W-1:0]);
                REG_COUNT:   count_reg   <= pwdata[CNT_W-1:0];
                REG_WEIGHTS: weights_reg <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_MODE:    prdata = DATA_W'(mode_reg);
            REG_COUNT:   prdata = DATA_W'(count_reg);
            REG_WEIGHTS: prdata = weights_reg;
            default:     prdata = '0;
        endcase
    end

    assign mode           = mode_reg;
    assign backend_count  = count_reg;
    assign weights_packed = weights_reg;
endmodule

### rtl/bsel_ctrl.sv
// sequencing state machine
module bsel_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  bsel_pkg::dp_stat_t   stat,
    output bsel_pkg::ctrl_cmd_t  cmd
);
    import bsel_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_START  = 12'b000000000010,
        S_MOD    = 12'b000000000100,
        S_SINIT  = 12'b000000001000,
        S_SCAN   = 12'b000000010000,
        S_WRR    = 12'b000000100000,
        S_LC_CHK = 12'b000001000000,
        S_LC_DIV = 12'b000010000000,
        S_LC_CMP = 12'b000100000000,
        S_BEST   = 12'b001000000000,
        S_UPD    = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!stat.is_select)
                    state_next = S_UPD;
                else
                begin
                    unique case (stat.mode)
                        MODE_WRR:
                        begin
                            cmd.sel_init = 1'b1;
                            state_next   = S_WRR;
                        end
                        MODE_LC:
                        begin
                            cmd.sel_init = 1'b1;
                            state_next   = S_LC_CHK;
                        end
                        MODE_HASH:
                        begin
                            cmd.mod_init    = 1'b1;
                            cmd.mod_src_key = 1'b1;
                            state_next      = S_MOD;
                        end
                        default:
                        begin
                            cmd.mod_init = 1'b1;
                            state_next   = S_MOD;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                    state_next = S_SINIT;
            end
            S_SINIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.up_cur || stat.k_last)
                    state_next = S_DONE;
            end
            S_WRR:
            begin
                cmd.wrr_step = 1'b1;
                if (stat.i_last)
                begin
                    if (stat.found || stat.up_cur)
                        state_next = S_BEST;
                    else
                    begin
                        cmd.mod_init = 1'b1;
                        state_next   = S_MOD;
                    end
                end
            end
            S_LC_CHK:
            begin
                if (stat.up_cur)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_LC_DIV;
                end
                else
                begin
                    cmd.lc_skip = 1'b1;
                    if (stat.i_last)
                    begin
                        if (stat.found)
                            state_next = S_BEST;
                        else
                        begin
                            cmd.mod_init = 1'b1;
                            state_next   = S_MOD;
                        end
                    end
                end
            end
            S_LC_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_LC_CMP;
            end
            S_LC_CMP:
            begin
                cmd.lc_cmp = 1'b1;
                state_next = stat.i_last ? S_BEST : S_LC_CHK;
            end
            S_BEST:
            begin
                cmd.res_best = 1'b1;
                cmd.wrr_fix  = (stat.mode == MODE_WRR);
                state_next   = S_DONE;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

### rtl/bsel_dp.sv
// backend state, modulo unit, divider and selection datapath
module bsel_dp #(
    parameter int NUM_BACKENDS = bsel_pkg::NUM_BACKENDS_DEF,
    parameter int WEIGHT_BITS  = bsel_pkg::WEIGHT_BITS_DEF,
    parameter int MAX_ACTIVE   = bsel_pkg::MAX_ACTIVE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bsel_pkg::ctrl_cmd_t          cmd,
    output bsel_pkg::dp_stat_t           stat,
    input  logic [bsel_pkg::CMD_W-1:0]   command,
    input  logic [bsel_pkg::IDX_W-1:0]   target_backend,
    input  logic                         healthy_bit,
    input  logic [bsel_pkg::KEY_W-1:0]   client_key,
    input  bsel_pkg::mode_t              mode,
    input  logic [bsel_pkg::CNT_W-1:0]   backend_count,
    input  logic [bsel_pkg::DATA_W-1:0]  weights_packed,
    output logic [bsel_pkg::IDX_W-1:0]   chosen_backend,
    output logic                         none_healthy
);
    import bsel_pkg::*;

    localparam int IW = $clog2(NUM_BACKENDS);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(RW_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(RW_MIN);

    cmd_t                     cmd_reg;
    logic                     hb_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [IDX_W-1:0]         rr_next_reg;
    logic signed [RW_W-1:0]   rw_reg [NUM_BACKENDS];
    logic                     up_reg [NUM_BACKENDS];
    logic [ACT_W-1:0]         act_reg [NUM_BACKENDS];
    logic [IDX_W-1:0]         i_reg, k_reg, start_reg, best_reg;
    logic                     scan_hash_reg, found_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [KEY_W-1:0]         msh_reg;
    logic [MCNT_W-1:0]        mcnt_reg;
    logic signed [RW_W-1:0]   best_rw_reg;
    logic [TOT_W-1:0]         total_reg;
    logic [SCORE_W-1:0]       min_reg, dvd_reg;
    logic [WGT_W-1:0]         drem_reg;
    logic [DCNT_W-1:0]        dcnt_reg;
    logic [IDX_W-1:0]         res_idx_reg, out_idx_reg;
    logic                     res_none_reg, out_none_reg;

    logic [CNT_W-1:0]         n_use, n_m1;
    logic [IW-1:0]            ii;
    logic                     up_cur, i_last, k_last;
    logic [WEIGHT_BITS-1:0]   w_raw;
    logic [WGT_W-1:0]         w_cur;
    logic [IDX_W-1:0]         i_inc;
    logic [CNT_W-1:0]         rem_next;
    logic signed [RW_W-1:0]   rw_add, rw_fix;
    logic [WGT_W:0]           dr;
    logic [SCORE_W-1:0]       dq;

    function automatic logic [CNT_W-1:0] mod_bit(input logic [CNT_W-1:0] r,
                                                 input logic b,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W:0] t;
        t = {r, b};
        if (t >= {1'b0, n})
            t = t - {1'b0, n};
        return t[CNT_W-1:0];
    endfunction

    function automatic logic signed [RW_W-1:0] sat_rw(input logic signed [SUM_W-1:0] v);
        if (v > SAT_HI)
            return RW_W'(RW_MAX);
        if (v < SAT_LO)
            return RW_W'(RW_MIN);
        return v[RW_W-1:0];
    endfunction

    always_comb
    begin
        if (backend_count == '0)
            n_use = CNT_W'(1);
        else if (backend_count > CNT_W'(NUM_BACKENDS))
            n_use = CNT_W'(NUM_BACKENDS);
        else
            n_use = backend_count;
    end

    assign n_m1   = n_use - CNT_W'(1);
    assign ii     = i_reg[IW-1:0];
    assign up_cur = up_reg[ii];
    assign i_last = ({1'b0, i_reg} == n_m1);
    assign k_last = ({1'b0, k_reg} == n_m1);
    assign i_inc  = i_last ? '0 : i_reg + IDX_W'(1);
    assign w_raw  = weights_packed[{i_reg, 3'b000} +: WEIGHT_BITS];
    assign w_cur  = (w_raw == '0) ? WGT_W'(1) : WGT_W'(w_raw);

    assign rem_next = mod_bit(mod_bit(rem_reg, msh_reg[KEY_W-1], n_use),
                              msh_reg[KEY_W-2], n_use);

    assign rw_add = sat_rw(SUM_W'(rw_reg[ii]) + $signed(SUM_W'(w_cur)));
    assign rw_fix = sat_rw(SUM_W'(best_rw_reg) - $signed(SUM_W'(total_reg)));

    always_comb
    begin
        dr = {1'b0, drem_reg};
        dq = dvd_reg;
        for (int j = 0; j < QBITS_STEP; j++)
        begin
            dr = {dr[WGT_W-1:0], dq[SCORE_W-1]};
            dq = {dq[SCORE_W-2:0], 1'b0};
            if (dr >= {1'b0, w_cur})
            begin
                dr    = dr - {1'b0, w_cur};
                dq[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.is_select = (cmd_reg == CMD_SELECT);
        stat.mode      = mode;
        stat.mod_last  = (mcnt_reg == MCNT_W'(MOD_STEPS - 1));
        stat.k_last    = k_last;
        stat.i_last    = i_last;
        stat.up_cur    = up_cur;
        stat.found     = found_reg;
        stat.div_last  = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));
    end

    // backend state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rr_next_reg <= '0;
            for (int b = 0; b < NUM_BACKENDS; b++)
            begin
                rw_reg[b]  <= '0;
                up_reg[b]  <= 1'b1;
                act_reg[b] <= '0;
            end
        end
        else
        begin
            if (cmd.scan_step && !scan_hash_reg)
            begin
                if (up_cur)
                    rr_next_reg <= i_inc;
                else if (k_last)
                    rr_next_reg <= start_reg;
            end
            if (cmd.wrr_step && up_cur)
                rw_reg[ii] <= rw_add;
            if (cmd.wrr_fix)
                rw_reg[best_reg[IW-1:0]] <= rw_fix;
            if (cmd.upd && ({1'b0, i_reg} < CNT_W'(NUM_BACKENDS)))
            begin
                case (cmd_reg)
                    CMD_HEALTH: up_reg[ii] <= hb_reg;
                    CMD_OPEN:
                        if (act_reg[ii] < ACT_W'(MAX_ACTIVE))
                            act_reg[ii] <= act_reg[ii] + ACT_W'(1);
                    CMD_CLOSE:
                        if (act_reg[ii] != '0)
                            act_reg[ii] <= act_reg[ii] - ACT_W'(1);
                    default: ;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg      <= cmd_t'(command);
            i_reg        <= target_backend;
            hb_reg       <= healthy_bit;
            key_reg      <= client_key;
            res_idx_reg  <= '0;
            res_none_reg <= 1'b0;
        end
        if (cmd.mod_init)
        begin
            msh_reg       <= cmd.mod_src_key ? key_reg : KEY_W'(rr_next_reg);
            scan_hash_reg <= cmd.mod_src_key;
            rem_reg       <= '0;
            mcnt_reg      <= '0;
        end
        if (cmd.mod_step)
        begin
            rem_reg  <= rem_next;
            msh_reg  <= {msh_reg[KEY_W-3:0], 2'b00};
            mcnt_reg <= mcnt_reg + MCNT_W'(1);
        end
        if (cmd.scan_init)
        begin
            i_reg     <= rem_reg[IDX_W-1:0];
            start_reg <= rem_reg[IDX_W-1:0];
            k_reg     <= '0;
        end
        if (cmd.scan_step)
        begin
            if (up_cur)
                res_idx_reg <= i_reg;
            else if (k_last)
            begin
                res_idx_reg  <= start_reg;
                res_none_reg <= 1'b1;
            end
            else
            begin
                i_reg <= i_inc;
                k_reg <= k_reg + IDX_W'(1);
            end
        end
        if (cmd.sel_init)
        begin
            i_reg     <= '0;
            found_reg <= 1'b0;
            total_reg <= '0;
        end
        if (cmd.wrr_step)
        begin
            if (up_cur)
            begin
                total_reg <= total_reg + TOT_W'(w_cur);
                if (!found_reg || rw_add > best_rw_reg)
                begin
                    best_reg    <= i_reg;
                    best_rw_reg <= rw_add;
                    found_reg   <= 1'b1;
                end
            end
            i_reg <= i_reg + IDX_W'(1);
        end
        if (cmd.lc_skip)
            i_reg <= i_reg + IDX_W'(1);
        if (cmd.div_init)
        begin
            dvd_reg  <= SCORE_W'(act_reg[ii]) * SCORE_W'(SCORE_SCALE);
            drem_reg <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dvd_reg  <= dq;
            drem_reg <= dr[WGT_W-1:0];
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
        if (cmd.lc_cmp)
        begin
            if (!found_reg || dvd_reg < min_reg)
            begin
                min_reg   <= dvd_reg;
                best_reg  <= i_reg;
                found_reg <= 1'b1;
            end
            i_reg <= i_reg + IDX_W'(1);
        end
        if (cmd.res_best)
            res_idx_reg <= best_reg;
        if (cmd.out_load)
        begin
            out_idx_reg  <= res_idx_reg;
            out_none_reg <= res_none_reg;
        end
    end

    assign chosen_backend = out_idx_reg;
    assign none_healthy   = out_none_reg;
endmodule

### rtl/backend_selector.sv
// backend selector top level
// non-selects update the backend state; selects use the configured mode:
// weighted, least connections (a divider per healthy backend), round robin and hash
//   (a modulo of the pointer or the key); the first two fall back to round robin if none healthy
// throughput: one word processed at a time; the next word is taken once the result is registered
// reset: asynchronous active low; all backends healthy, counts and running weights cleared
module backend_selector #(
    parameter int NUM_BACKENDS = bsel_pkg::NUM_BACKENDS_DEF,
    parameter int WEIGHT_BITS  = bsel_pkg::WEIGHT_BITS_DEF,
    parameter int MAX_ACTIVE   = bsel_pkg::MAX_ACTIVE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsel_pkg::ADDR_W-1:0]  paddr,
    input  logic [bsel_pkg::DATA_W-1:0]  pwdata,
    output logic [bsel_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    bsel_in_if.sink                      in_ch,
    bsel_out_if.source                   out_ch
);
    import bsel_pkg::*;

    mode_t              mode;
    logic [CNT_W-1:0]   backend_count;
    logic [DATA_W-1:0]  weights_packed;
    ctrl_cmd_t          cmd;
    dp_stat_t           stat;

    bsel_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mode           (mode),
        .backend_count  (backend_count),
        .weights_packed (weights_packed)
    );

    bsel_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bsel_dp #(
        .NUM_BACKENDS (NUM_BACKENDS),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .MAX_ACTIVE   (MAX_ACTIVE)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .command        (in_ch.command),
        .target_backend (in_ch.target_backend),
        .healthy_bit    (in_ch.healthy_bit),
        .client_key     (in_ch.client_key),
        .mode           (mode),
        .backend_count  (backend_count),
        .weights_packed (weights_packed),
        .chosen_backend (out_ch.chosen_backend),
        .none_healthy   (out_ch.none_healthy)
    );
endmodule

### rtl/bsel_chk.sv
// port level checks for the backend selector
module bsel_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [bsel_pkg::IDX_W-1:0]  chosen_backend,
    input logic                        none_healthy
);
    logic [1:0] pend_reg;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(chosen_backend) && $stable(none_healthy))
        else $error("result word changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pend_reg != 2'd0)
        else $error("result word without a request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pend_reg < 2'd2)
        else $error("more than two words in flight");
endmodule

bind backend_selector bsel_chk u_bsel_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .chosen_backend (out_ch.chosen_backend),
    .none_healthy   (out_ch.none_healthy)
);

### bench/tb_backend_selector.sv
// testbench for the backend selector: directed table then random commands, checked by a predictor
`timescale 1ns / 100ps

module tb_backend_selector;
    import bsel_pkg::*;

    localparam int NB = 8;
    localparam int ACT_LIMIT = 4096;
    localparam int N_RANDOM = 1630;

    typedef struct {
        cmd_t         command;
        logic [2:0]   target_backend;
        logic         healthy_bit;
        logic [31:0]  client_key;
    } request_t;

    typedef struct {
        logic [2:0] chosen_backend;
        logic       none_healthy;
    } choice_t;

    typedef struct {
        request_t req;
        logic     known;
        choice_t  res;
    } table_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    bsel_in_if in_ch ();
    bsel_out_if out_ch ();

    backend_selector dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    // predictor state
    mode_t       cur_mode;
    logic [3:0]  cur_count;
    logic [63:0] cur_weights;
    int          rr_ptr;
    int          run_wt [NB];
    logic        up [NB];
    int          conns [NB];

    choice_t pending_choices [$];
    int      error_count;
    int      result_count;
    int      select_count;
    int      none_count;
    bit      stim_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("FAILURE");
        $finish;
    end

    function automatic int used_count();
        if (cur_count == 0) return 1;
        if (cur_count > NB) return NB;
        return cur_count;
    endfunction

    function automatic int weight_at(int i);
        int w;
        w = cur_weights[8*i +: 8];
        return (w == 0) ? 1 : w;
    endfunction

    function automatic int clamp_wt(int v);
        if (v > RW_MAX) return RW_MAX;
        if (v < RW_MIN) return RW_MIN;
        return v;
    endfunction

    function automatic int round_robin_pick(int n, ref logic none);
        int start;
        int idx;
        start = rr_ptr % n;
        for (int k = 0; k < n; k++)
        begin
            idx = (start + k) % n;
            if (up[idx])
            begin
                rr_ptr = (idx + 1) % n;
                return idx;
            end
        end
        rr_ptr = start;
        none = 1'b1;
        return start;
    endfunction

    function automatic choice_t predict_choice(request_t r);
        choice_t c;
        int n;
        int best;
        int total;
        longint score;
        longint low_score;
        logic none;
        int pick;
        none = 1'b0;
        pick = 0;
        if (r.command == CMD_SELECT)
        begin
            n = used_count();
            best = -1;
            case (cur_mode)
                MODE_WRR:
                begin
                    total = 0;
                    for (int i = 0; i < n; i++)
                    begin
                        if (!up[i]) continue;
                        run_wt[i] = clamp_wt(run_wt[i] + weight_at(i));
                        total += weight_at(i);
                        if (best < 0 || run_wt[i] > run_wt[best]) best = i;
                    end
                    if (best < 0) pick = round_robin_pick(n, none);
                    else
                    begin
                        run_wt[best] = clamp_wt(run_wt[best] - total);
                        pick = best;
                    end
                end
                MODE_LC:
                begin
                    low_score = 0;
                    for (int i = 0; i < n; i++)
                    begin
                        if (!up[i]) continue;
                        score = (conns[i] * 100) / weight_at(i);
                        if (best < 0 || score < low_score)
                        begin
                            low_score = score;
                            best = i;
                        end
                    end
                    pick = (best < 0) ? round_robin_pick(n, none) : best;
                end
                MODE_HASH:
                begin
                    best = r.client_key % n;
                    pick = -1;
                    for (int k = 0; k < n && pick < 0; k++)
                        if (up[(best + k) % n]) pick = (best + k) % n;
                    if (pick < 0)
                    begin
                        pick = best;
                        none = 1'b1;
                    end
                end
                default: pick = round_robin_pick(n, none);
            endcase
        end
        else if (r.command == CMD_HEALTH)
            up[r.target_backend] = r.healthy_bit;
        else if (r.command == CMD_OPEN)
        begin
            if (conns[r.target_backend] < ACT_LIMIT) conns[r.target_backend]++;
        end
        else if (conns[r.target_backend] > 0)
            conns[r.target_backend]--;
        c.chosen_backend = pick[2:0];
        c.none_healthy = none;
        return c;
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * idx);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE:    cur_mode = mode_t'(value[1:0]);
            REG_COUNT:   cur_count = value[3:0];
            REG_WEIGHTS: cur_weights = value;
            default: ;
        endcase
    endtask

    task automatic send_word(request_t r, logic known, choice_t want);
        choice_t c;
        int gap;
        gap = $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= r.command;
        in_ch.target_backend <= r.target_backend;
        in_ch.healthy_bit <= r.healthy_bit;
        in_ch.client_key <= r.client_key;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        c = predict_choice(r);
        if (known)
        begin
            if (c.chosen_backend !== want.chosen_backend)
            begin
                $error("table chosen_backend expected %0d actual %0d",
                       want.chosen_backend, c.chosen_backend);
                error_count++;
            end
            if (c.none_healthy !== want.none_healthy)
            begin
                $error("table none_healthy expected %0d actual %0d",
                       want.none_healthy, c.none_healthy);
                error_count++;
            end
            c = want;
        end
        if (r.command == CMD_SELECT)
        begin
            select_count++;
            none_count += c.none_healthy;
        end
        pending_choices.push_back(c);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (pending_choices.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
    endtask

    function automatic request_t mk(cmd_t cmd, int tgt, int hb, logic [31:0] key);
        request_t r;
        r.command = cmd;
        r.target_backend = tgt[2:0];
        r.healthy_bit = hb[0];
        r.client_key = key;
        return r;
    endfunction

    function automatic request_t random_request();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return mk(CMD_SELECT, $urandom_range(0, 7), $urandom_range(0, 1), $urandom());
        if (p < 70) return mk(CMD_HEALTH, $urandom_range(0, 7), ($urandom_range(0, 3) != 0),
                              $urandom());
        if (p < 88) return mk(CMD_OPEN, $urandom_range(0, 7), $urandom_range(0, 1), $urandom());
        return mk(CMD_CLOSE, $urandom_range(0, 7), $urandom_range(0, 1), $urandom());
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            result_count++;
            if (pending_choices.size() == 0)
            begin
                $error("unexpected word: backend %0d", out_ch.chosen_backend);
                error_count++;
            end
            else
            begin
                choice_t want;
                want = pending_choices.pop_front();
                if (out_ch.chosen_backend !== want.chosen_backend)
                begin
                    $error("chosen_backend expected %0d actual %0d",
                           want.chosen_backend, out_ch.chosen_backend);
                    error_count++;
                end
                if (out_ch.none_healthy !== want.none_healthy)
                begin
                    $error("none_healthy expected %0d actual %0d",
                           want.none_healthy, out_ch.none_healthy);
                    error_count++;
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stim_done) gap = 0;
            if (gap != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    initial
    begin
        table_row_t rows [$];
        request_t r;
        choice_t dontcare;
        logic [63:0] wv;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_SELECT;
        in_ch.target_backend = '0;
        in_ch.healthy_bit = 1'b0;
        in_ch.client_key = '0;
        error_count = 0;
        result_count = 0;
        select_count = 0;
        none_count = 0;
        stim_done = 0;
        dontcare = '{3'd0, 1'b0};
        cur_mode = MODE_WRR;
        cur_count = COUNT_RESET;
        cur_weights = WEIGHTS_RESET;
        rr_ptr = 0;
        for (int i = 0; i < NB; i++)
        begin
            run_wt[i] = 0;
            up[i] = 1'b1;
            conns[i] = 0;
        end
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: one backend, weighted mode
        rows.push_back('{mk(CMD_SELECT, 0, 0, 32'd0), 1'b1, '{3'd0, 1'b0}});
        rows.push_back('{mk(CMD_HEALTH, 0, 0, 32'hffffffff), 1'b1, '{3'd0, 1'b0}});
        rows.push_back('{mk(CMD_SELECT, 7, 1, 32'd5), 1'b1, '{3'd0, 1'b1}});
        rows.push_back('{mk(CMD_HEALTH, 0, 1, 32'd0), 1'b1, '{3'd0, 1'b0}});
        rows.push_back('{mk(CMD_CLOSE, 3, 0, 32'd0), 1'b1, '{3'd0, 1'b0}});
        rows.push_back('{mk(CMD_OPEN, 7, 1, 32'd0), 1'b1, '{3'd0, 1'b0}});
        foreach (rows[i]) send_word(rows[i].req, rows[i].known, rows[i].res);
        drain();

        // every mode at full count and extreme weights, with unhealthy backends
        for (int m = 0; m < 4; m++)
        begin
            write_reg(REG_MODE, 64'(m));
            write_reg(REG_COUNT, (m == 1) ? 64'd15 : 64'd8);
            write_reg(REG_WEIGHTS, (m == 1) ? 64'hffffffffffffffff : 64'h00ff0180_7f0302ff);
            send_word(mk(CMD_SELECT, 0, 0, 32'hffffffff), 0, dontcare);
            send_word(mk(CMD_HEALTH, m * 2, 0, 32'd0), 0, dontcare);
            send_word(mk(CMD_SELECT, 0, 0, 32'h80000000), 0, dontcare);
            send_word(mk(CMD_OPEN, 1, 0, 32'd0), 0, dontcare);
            send_word(mk(CMD_SELECT, 0, 0, 32'd3), 0, dontcare);
            drain();
        end
        for (int i = 0; i < NB; i++) send_word(mk(CMD_HEALTH, i, 1, 32'd0), 0, dontcare);
        drain();

        // random phases over settings
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(REG_MODE, 64'($urandom_range(0, 3)));
            write_reg(REG_COUNT, (ph == 0) ? 64'd0 : 64'($urandom_range(0, 15)));
            wv = {$urandom(), $urandom()};
            if (ph == 1) wv = '0;
            if (ph == 2) wv = '1;
            write_reg(REG_WEIGHTS, wv);
            for (int k = 0; k < N_RANDOM / 10; k++)
            begin
                r = random_request();
                if (ph == 3 && r.command == CMD_CLOSE) r.command = CMD_OPEN;
                send_word(r, 0, dontcare);
            end
            drain();
        end
        // least connections on the accumulated counts
        write_reg(REG_MODE, 64'(MODE_LC));
        send_word(mk(CMD_SELECT, 0, 0, 32'd0), 0, dontcare);
        stim_done = 1;
        drain();

        $display("covered %0d words, %0d selects, %0d with no healthy backend",
                 result_count, select_count, none_count);
        if (error_count == 0 && pending_choices.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
